// File: src/lzwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants of the LZSS window decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam int MAX_WINDOW_BITS_DEF    = 10;
  localparam int MAX_LOOKAHEAD_BITS_DEF = 6;
  localparam int LITERAL_WIDTH          = 8;

  localparam logic [3:0] WINDOW_BITS_RST    = 4'd8;
  localparam logic [2:0] LOOKAHEAD_BITS_RST = 3'd4;

  localparam logic       CMD_DATA    = 1'b0;
  localparam logic       CMD_RESTART = 1'b1;

  localparam logic [0:0] REG_WINDOW_BITS    = 1'd0;
  localparam logic [0:0] REG_LOOKAHEAD_BITS = 1'd1;

  localparam logic [1:0] PH_TAG = 2'd0;
  localparam logic [1:0] PH_LIT = 2'd1;
  localparam logic [1:0] PH_OFF = 2'd2;
  localparam logic [1:0] PH_LEN = 2'd3;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       from_copy;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [3:0] index;
    logic [7:0] data;
  } cfg_item_t;

endpackage

// File: src/lzwd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_parser
// Front end: walks the bits of each compressed byte, one bit per cycle unless
// the queue is full, and issues literal, copy and no-op commands to the queue.
// ----------------------------------------------------------------------------
module lzwd_parser #(
  parameter int MaxWindowBits    = lzwd_pkg::MAX_WINDOW_BITS_DEF,
  parameter int MaxLookaheadBits = lzwd_pkg::MAX_LOOKAHEAD_BITS_DEF,
  parameter int CmdWidth         = 3 + MaxWindowBits + MaxLookaheadBits + 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  lzwd_pkg::in_item_t           item,
  input  logic [$clog2(MaxWindowBits+1)-1:0]    eff_wbits,
  input  logic [$clog2(MaxLookaheadBits+1)-1:0] eff_lbits,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output logic [CmdWidth-1:0]          cmd_data
);

  localparam int AccW = (MaxWindowBits > 8) ? MaxWindowBits : 8;
  localparam int CntW = $clog2(AccW + 1);
  localparam int BitW = 3;

  // Command word: {kind[1:0], last, distance-1, length-1 or literal, 2'b00}.
  // A byte completes at most one token, so every issued command is the
  // last of its item.
  localparam logic [1:0] K_LIT   = 2'd0;
  localparam logic [1:0] K_COPY  = 2'd1;
  localparam logic [1:0] K_NONE  = 2'd3;

  logic             busy;
  logic [7:0]       sh;
  logic [BitW-1:0]  bitcnt;
  logic [1:0]       phase;
  logic [AccW-1:0]  acc;
  logic [CntW-1:0]  left;
  logic [MaxWindowBits-1:0] offset;
  logic             produced;

  logic             b;
  logic             lastbit;
  logic [AccW-1:0]  acc_n;
  logic [1:0]       kind;
  logic [AccW-1:0]  payload;
  logic             stall;

  assign full = busy;
  assign b = sh[7];
  assign lastbit = (bitcnt == BitW'(7));
  assign acc_n = {acc[AccW-2:0], b};

  always_comb begin
    kind = K_NONE;
    payload = acc_n;
    if (phase != lzwd_pkg::PH_TAG && left == CntW'(1)) begin
      if (phase == lzwd_pkg::PH_LIT) kind = K_LIT;
      else if (phase == lzwd_pkg::PH_LEN) kind = K_COPY;
    end
  end

  logic issue;
  assign issue = busy && ((kind != K_NONE) || (lastbit && !produced));
  assign stall = issue && !cmd_ready;
  assign cmd_valid = issue;

  always_comb begin
    cmd_data = {kind, 1'b1, offset, payload[MaxLookaheadBits-1:0], 2'b00};
    if (kind == K_LIT) cmd_data[9:2] = payload[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sh <= '0;
      phase <= lzwd_pkg::PH_TAG;
      left <= '0;
      acc <= '0;
      offset <= '0;
      bitcnt <= '0;
      produced <= 1'b0;
    end else if (!busy) begin
      if (push) begin
        if (item.cmd == lzwd_pkg::CMD_RESTART) begin
          phase <= lzwd_pkg::PH_TAG;
          left <= '0;
          acc <= '0;
          offset <= '0;
        end else begin
          busy <= 1'b1;
          sh <= item.in_byte;
          bitcnt <= '0;
          produced <= 1'b0;
        end
      end
    end else if (!stall) begin
      sh <= {sh[6:0], 1'b0};
      bitcnt <= bitcnt + BitW'(1);
      if (kind != K_NONE) produced <= 1'b1;
      if (lastbit) busy <= 1'b0;
      if (phase == lzwd_pkg::PH_TAG) begin
        acc <= '0;
        if (b) begin
          phase <= lzwd_pkg::PH_LIT;
          left <= CntW'(lzwd_pkg::LITERAL_WIDTH);
        end else begin
          phase <= lzwd_pkg::PH_OFF;
          left <= CntW'(eff_wbits);
        end
      end else begin
        acc <= acc_n;
        if (left != CntW'(1) && left != '0) begin
          left <= left - CntW'(1);
        end else if (phase == lzwd_pkg::PH_OFF) begin
          offset <= acc_n[MaxWindowBits-1:0];
          acc <= '0;
          left <= CntW'(eff_lbits);
          phase <= lzwd_pkg::PH_LEN;
        end else begin
          left <= '0;
          phase <= lzwd_pkg::PH_TAG;
        end
      end
    end
  end

endmodule

// File: src/lzwd_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_cmd_queue
// Short command queue between the token parser and the copy engine.
// ----------------------------------------------------------------------------
module lzwd_cmd_queue #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [Width-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [Width-1:0] rd_data
);

  localparam int AW = $clog2(Depth);

  logic [Width-1:0] mem [Depth];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [AW:0]      cnt;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (cnt != (AW+1)'(Depth));
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rp];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wr_data;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) wp <= (wp == AW'(Depth-1)) ? '0 : wp + AW'(1);
      if (do_rd) rp <= (rp == AW'(Depth-1)) ? '0 : rp + AW'(1);
      cnt <= cnt + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

endmodule

// File: src/lzwd_copy_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_copy_engine
// Back end: owns the history window, writes literals and runs copies one
// byte per read, and clears the window after reset and on restart.
// ----------------------------------------------------------------------------
module lzwd_copy_engine #(
  parameter int MaxWindowBits    = lzwd_pkg::MAX_WINDOW_BITS_DEF,
  parameter int MaxLookaheadBits = lzwd_pkg::MAX_LOOKAHEAD_BITS_DEF,
  parameter int CmdWidth         = 3 + MaxWindowBits + MaxLookaheadBits + 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [MaxWindowBits-1:0] wmask,
  input  logic                   clear_req,
  output logic                   clearing,
  output logic                   idle,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  logic [CmdWidth-1:0]    cmd_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lzwd_pkg::out_item_t    out_item
);

  localparam int Depth = 1 << MaxWindowBits;
  localparam int LenW  = MaxLookaheadBits + 1;

  localparam logic [1:0] K_LIT  = 2'd0;
  localparam logic [1:0] K_COPY = 2'd1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  logic [7:0] win [Depth];

  logic [1:0]               state;
  logic [MaxWindowBits-1:0] head;
  logic [MaxWindowBits-1:0] offset;
  logic [LenW-1:0]          remain;
  logic                     lastflag;
  logic [MaxWindowBits-1:0] clr_addr;
  logic [7:0]               rdata;

  logic [1:0]                  c_kind;
  logic                        c_last;
  logic [MaxWindowBits-1:0]    c_dist;
  logic [MaxLookaheadBits-1:0] c_len;
  logic [7:0]                  c_lit;
  logic                        out_free;
  logic                        load_out;

  assign c_kind = cmd_data[CmdWidth-1 -: 2];
  assign c_last = cmd_data[CmdWidth-3];
  assign c_dist = cmd_data[MaxLookaheadBits+2 +: MaxWindowBits];
  assign c_len  = cmd_data[2 +: MaxLookaheadBits];
  assign c_lit  = cmd_data[9:2];

  assign out_free  = !out_valid || out_ready;
  assign clearing  = (state == S_CLEAR);
  assign idle      = (state == S_IDLE);
  assign cmd_ready = (state == S_IDLE) && out_free && !clear_req;
  assign load_out  = (state == S_IDLE && cmd_valid && cmd_ready && c_kind == K_LIT) ||
                     (state == S_WRITE && out_free);

  always_ff @(posedge clk) begin
    rdata <= win[(head - offset - MaxWindowBits'(1)) & wmask];
    if (state == S_CLEAR) begin
      win[clr_addr] <= 8'd0;
    end else if (state == S_IDLE && cmd_valid && cmd_ready && c_kind == K_LIT) begin
      win[head & wmask] <= c_lit;
    end else if (state == S_WRITE && out_free) begin
      win[head & wmask] <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      head <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (clear_req) begin
            state <= S_CLEAR;
            clr_addr <= '0;
            head <= '0;
          end else if (cmd_valid && cmd_ready) begin
            if (c_kind == K_LIT) begin
              out_item.out_byte <= c_lit;
              out_item.from_copy <= 1'b0;
              out_item.last <= c_last;
              head <= head + MaxWindowBits'(1);
            end else if (c_kind == K_COPY) begin
              offset <= c_dist;
              remain <= LenW'(c_len) + LenW'(1);
              lastflag <= c_last;
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_WRITE;
        S_WRITE: begin
          if (out_free) begin
            out_item.out_byte <= rdata;
            out_item.from_copy <= 1'b1;
            out_item.last <= lastflag && (remain == LenW'(1));
            head <= head + MaxWindowBits'(1);
            remain <= remain - LenW'(1);
            state <= (remain == LenW'(1)) ? S_IDLE : S_READ;
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + MaxWindowBits'(1);
          if (clr_addr == MaxWindowBits'(Depth-1)) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/lzss_window_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_window_decoder
// LZSS decompressor with a circular history window.
//
// Channel  | Handshake        | Payload
// input    | push / full      | in_item  {cmd, in_byte}
// result   | pop / empty      | out_item {out_byte, from_copy, last}
// config   | cfg_valid/ready  | cfg      {index, data}
//
// The parser takes one bit per cycle while the queue has room, and a data item
// holds the input until all its bits are taken. The copy engine emits each copied
// byte by a window read, then a write. After reset and each restart the whole
// window of 2^MaxWindowBits entries is cleared, and no item is accepted meanwhile.
// A restart also waits until the command queue and copy engine are idle. Results
// stall the engine; the parser stalls only on a full four-entry command queue.
// ----------------------------------------------------------------------------
module lzss_window_decoder #(
  parameter int MaxWindowBits    = lzwd_pkg::MAX_WINDOW_BITS_DEF,
  parameter int MaxLookaheadBits = lzwd_pkg::MAX_LOOKAHEAD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  lzwd_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output lzwd_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  lzwd_pkg::cfg_item_t cfg
);

  localparam int CmdWidth = 3 + MaxWindowBits + MaxLookaheadBits + 2;
  localparam int WbW = $clog2(MaxWindowBits + 1);
  localparam int LbW = $clog2(MaxLookaheadBits + 1);

  logic [3:0] window_bits;
  logic [2:0] lookahead_bits;
  logic [WbW-1:0] eff_wbits;
  logic [LbW-1:0] eff_lbits;
  logic [MaxWindowBits-1:0] wmask;

  logic p_full;
  logic restart;
  logic clearing;
  logic eng_idle;
  logic pq_valid, pq_ready, qe_valid, qe_ready;
  logic [CmdWidth-1:0] pq_data, qe_data;
  logic out_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= lzwd_pkg::WINDOW_BITS_RST;
      lookahead_bits <= lzwd_pkg::LOOKAHEAD_BITS_RST;
    end else if (cfg_valid) begin
      if (cfg.index == 4'(lzwd_pkg::REG_WINDOW_BITS)) window_bits <= cfg.data[3:0];
      else if (cfg.index == 4'(lzwd_pkg::REG_LOOKAHEAD_BITS))
        lookahead_bits <= cfg.data[2:0];
    end
  end

  always_comb begin
    eff_wbits = (window_bits < 4'd4) ? WbW'(4) :
                (32'(window_bits) > MaxWindowBits) ? WbW'(MaxWindowBits) :
                WbW'(window_bits);
    eff_lbits = (lookahead_bits < 3'd3) ? LbW'(3) :
                (32'(lookahead_bits) > MaxLookaheadBits) ? LbW'(MaxLookaheadBits) :
                LbW'(lookahead_bits);
    wmask = MaxWindowBits'((32'd1 << eff_wbits) - 32'd1);
  end

  // A restart waits for the back end to drain, then starts a window clear.
  assign restart = push && !full && (in_item.cmd == lzwd_pkg::CMD_RESTART);
  assign full = p_full || clearing ||
                ((in_item.cmd == lzwd_pkg::CMD_RESTART) && (qe_valid || !eng_idle));

  lzwd_parser #(
    .MaxWindowBits(MaxWindowBits), .MaxLookaheadBits(MaxLookaheadBits),
    .CmdWidth(CmdWidth)
  ) u_parser (
    .clk, .rst, .push(push && !full), .full(p_full), .item(in_item),
    .eff_wbits, .eff_lbits,
    .cmd_valid(pq_valid), .cmd_ready(pq_ready), .cmd_data(pq_data)
  );

  lzwd_cmd_queue #(.Width(CmdWidth), .Depth(4)) u_queue (
    .clk, .rst, .wr_valid(pq_valid), .wr_ready(pq_ready), .wr_data(pq_data),
    .rd_valid(qe_valid), .rd_ready(qe_ready), .rd_data(qe_data)
  );

  lzwd_copy_engine #(
    .MaxWindowBits(MaxWindowBits), .MaxLookaheadBits(MaxLookaheadBits),
    .CmdWidth(CmdWidth)
  ) u_engine (
    .clk, .rst, .wmask, .clear_req(restart), .clearing, .idle(eng_idle),
    .cmd_valid(qe_valid), .cmd_ready(qe_ready), .cmd_data(qe_data),
    .out_valid, .out_ready(pop), .out_item
  );

  assign empty = !out_valid;

endmodule

// File: dv/lzss_window_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_window_decoder_tb
// Self-checking testbench for the LZSS window decoder.
//
// Compressed bytes go in through the push/full port. A software copy of the
// decoder predicts every decompressed byte, and the bytes are compared in
// order as they are popped. A short table of directed items comes first,
// then random token streams under several window and lookahead settings.
// Both sides pause at random, and once the receiver stalls long enough for
// the decoder to fill up and hold off its input.
// ----------------------------------------------------------------------------
module lzss_window_decoder_tb;

  localparam int WatchdogLimit = 20000;

  typedef struct {
    lzwd_pkg::in_item_t   item;
    logic                 check_first;
    lzwd_pkg::out_item_t  first_out;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  lzwd_pkg::in_item_t  in_item = '0;
  logic                empty;
  logic                pop = 1'b0;
  lzwd_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  lzwd_pkg::cfg_item_t cfg = '0;

  logic [3:0] window_bits_reg;
  logic [2:0] lookahead_bits_reg;
  logic [1:0] token_phase;
  logic [9:0] field_accum;
  logic [3:0] field_bits_left;
  logic [10:0] copy_distance;
  logic [9:0] write_head;
  logic [7:0] history_window [1024];

  lzwd_pkg::out_item_t expected_bytes[$];
  int        errors = 0;
  int        idle_cycles = 0;
  int        pop_wait = 0;
  bit        hold_off = 1'b0;
  bit        bit_queue[$];

  lzss_window_decoder i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg(cfg)
  );

  always #1 clk = ~clk;

  function automatic int clamp_window();
    if (window_bits_reg < 4) return 4;
    if (window_bits_reg > 10) return 10;
    return window_bits_reg;
  endfunction

  function automatic int clamp_lookahead();
    if (lookahead_bits_reg < 3) return 3;
    if (lookahead_bits_reg > 6) return 6;
    return lookahead_bits_reg;
  endfunction

  function automatic void clear_decoder();
    token_phase = lzwd_pkg::PH_TAG;
    field_accum = '0;
    field_bits_left = '0;
    copy_distance = '0;
    write_head = '0;
    foreach (history_window[i]) history_window[i] = '0;
  endfunction

  function automatic void store_byte(logic [7:0] b);
    int mask;
    mask = (1 << clamp_window()) - 1;
    history_window[write_head & mask] = b;
    write_head = write_head + 1'b1;
  endfunction

  // Runs one compressed byte through the decoder copy and returns its bytes.
  function automatic void decode_byte(lzwd_pkg::in_item_t it,
                                      ref lzwd_pkg::out_item_t outs[$]);
    logic b;
    int mask;
    int count;
    logic [7:0] c;
    outs = {};
    if (it.cmd == lzwd_pkg::CMD_RESTART) begin
      clear_decoder();
      return;
    end
    for (int i = 7; i >= 0; i--) begin
      b = it.in_byte[i];
      if (token_phase == lzwd_pkg::PH_TAG) begin
        field_accum = '0;
        if (b) begin
          token_phase = lzwd_pkg::PH_LIT;
          field_bits_left = 4'(lzwd_pkg::LITERAL_WIDTH);
        end else begin
          token_phase = lzwd_pkg::PH_OFF;
          field_bits_left = 4'(clamp_window());
        end
        continue;
      end
      field_accum = {field_accum[8:0], b};
      if (field_bits_left > 0) field_bits_left--;
      if (field_bits_left != 0) continue;
      if (token_phase == lzwd_pkg::PH_LIT) begin
        store_byte(field_accum[7:0]);
        outs.push_back('{field_accum[7:0], 1'b0, 1'b0});
        token_phase = lzwd_pkg::PH_TAG;
      end else if (token_phase == lzwd_pkg::PH_OFF) begin
        copy_distance = field_accum + 11'd1;
        field_accum = '0;
        field_bits_left = 4'(clamp_lookahead());
        token_phase = lzwd_pkg::PH_LEN;
      end else begin
        count = field_accum[6:0] + 1;
        mask = (1 << clamp_window()) - 1;
        for (int k = 0; k < count; k++) begin
          c = history_window[(write_head - copy_distance) & mask];
          store_byte(c);
          outs.push_back('{c, 1'b1, 1'b0});
        end
        token_phase = lzwd_pkg::PH_TAG;
      end
    end
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
  endfunction

  // Push stays high from one item to the next when there is no gap.
  task automatic send_item(lzwd_pkg::in_item_t it, logic check_first = 1'b0,
                           lzwd_pkg::out_item_t first_out = '0);
    lzwd_pkg::out_item_t outs[$];
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    decode_byte(it, outs);
    if (check_first) begin
      if (outs.size() == 0 || outs[0] !== first_out) begin
        $display("%0t directed first byte: expected %h actual %h", $time, first_out,
                 outs.size() ? outs[0] : '0);
        errors++;
      end
      if (outs.size() > 0) outs[0] = first_out;
    end
    foreach (outs[i]) expected_bytes.push_back(outs[i]);
  endtask

  task automatic end_burst();
    push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [7:0] data);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg <= '{idx, data};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == 4'(lzwd_pkg::REG_WINDOW_BITS)) window_bits_reg = data[3:0];
    else if (idx == 4'(lzwd_pkg::REG_LOOKAHEAD_BITS)) lookahead_bits_reg = data[2:0];
  endtask

  function automatic void add_bits(int value, int width);
    for (int i = width - 1; i >= 0; i--) bit_queue.push_back(value[i]);
  endfunction

  // Builds a token stream of literals and mostly short copies, rarely swapping in a random byte.
  task automatic send_stream(int n_items);
    lzwd_pkg::in_item_t it;
    int wb;
    int lb;
    int produced;
    wb = clamp_window();
    lb = clamp_lookahead();
    produced = 0;
    bit_queue = {};
    while (bit_queue.size() < n_items * 8) begin
      if ($urandom_range(0, 2) == 0 || produced == 0) begin
        add_bits(1, 1);
        add_bits($urandom_range(0, 255), 8);
        produced++;
      end else begin
        add_bits(0, 1);
        if ($urandom_range(0, 5) == 0) add_bits($urandom_range(0, (1 << wb) - 1), wb);
        else add_bits($urandom_range(0, (produced < 8 ? produced : 8) - 1), wb);
        add_bits($urandom_range(0, 9) == 0 ? (1 << lb) - 1 : $urandom_range(0, 3), lb);
        produced += 2;
      end
    end
    for (int k = 0; k < n_items; k++) begin
      it.cmd = lzwd_pkg::CMD_DATA;
      for (int i = 7; i >= 0; i--) it.in_byte[i] = bit_queue.pop_front();
      if ($urandom_range(0, 40) == 0) it = '{lzwd_pkg::CMD_DATA, 8'($urandom)};
      send_item(it);
    end
    end_burst();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t unexpected byte: expected none actual %h", $time, out_item);
          errors++;
        end else begin
          if (out_item.out_byte !== expected_bytes[0].out_byte ||
              out_item.from_copy !== expected_bytes[0].from_copy ||
              out_item.last !== expected_bytes[0].last) begin
            $display("%0t mismatch: expected %h actual %h", $time,
                     expected_bytes[0], out_item);
            errors++;
          end
          void'(expected_bytes.pop_front());
        end
        pop_wait = $urandom_range(0, 4);
      end else if (pop_wait > 0) begin
        pop_wait--;
      end
      pop <= !hold_off && (pop_wait == 0);
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    stim_row_t table_rows[$];
    lzwd_pkg::out_item_t z;
    z = '0;
    window_bits_reg = lzwd_pkg::WINDOW_BITS_RST;
    lookahead_bits_reg = lzwd_pkg::LOOKAHEAD_BITS_RST;
    clear_decoder();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Literal 0xFF, literal 0x00, a copy of the last byte, then a copy read from a cleared window.
    table_rows = '{
      '{'{lzwd_pkg::CMD_DATA, 8'hFF}, 1'b0, z},
      '{'{lzwd_pkg::CMD_DATA, 8'hC0}, 1'b1, '{8'hFF, 1'b0, 1'b1}},
      '{'{lzwd_pkg::CMD_DATA, 8'h00}, 1'b0, z},
      '{'{lzwd_pkg::CMD_DATA, 8'h00}, 1'b0, z},
      '{'{lzwd_pkg::CMD_DATA, 8'h7F}, 1'b0, z},
      '{'{lzwd_pkg::CMD_DATA, 8'hFF}, 1'b0, z},
      '{'{lzwd_pkg::CMD_DATA, 8'h55}, 1'b0, z},
      '{'{lzwd_pkg::CMD_DATA, 8'hAA}, 1'b0, z},
      '{'{lzwd_pkg::CMD_RESTART, 8'hFF}, 1'b0, z},
      '{'{lzwd_pkg::CMD_DATA, 8'h80}, 1'b0, z},
      '{'{lzwd_pkg::CMD_DATA, 8'h80}, 1'b1, '{8'h01, 1'b0, 1'b1}},
      '{'{lzwd_pkg::CMD_DATA, 8'h00}, 1'b0, z},
      '{'{lzwd_pkg::CMD_DATA, 8'h3F}, 1'b0, z},
      '{'{lzwd_pkg::CMD_DATA, 8'hF0}, 1'b0, z},
      '{'{lzwd_pkg::CMD_RESTART, 8'h00}, 1'b0, z}
    };
    foreach (table_rows[i])
      send_item(table_rows[i].item, table_rows[i].check_first, table_rows[i].first_out);
    end_burst();

    send_stream(60);

    // Receiver stalls while input keeps coming, so the decoder backs up.
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      send_stream(20);
    join

    write_reg(4'(lzwd_pkg::REG_WINDOW_BITS), 8'd4);
    write_reg(4'(lzwd_pkg::REG_LOOKAHEAD_BITS), 8'd3);
    send_stream(60);
    write_reg(4'(lzwd_pkg::REG_LOOKAHEAD_BITS), 8'd6);
    send_stream(40);
    write_reg(4'(lzwd_pkg::REG_WINDOW_BITS), 8'd10);
    send_stream(60);
    write_reg(4'(lzwd_pkg::REG_WINDOW_BITS), 8'd15);
    write_reg(4'(lzwd_pkg::REG_LOOKAHEAD_BITS), 8'd0);
    send_stream(40);
    write_reg(4'(lzwd_pkg::REG_WINDOW_BITS), 8'd0);
    write_reg(4'(lzwd_pkg::REG_LOOKAHEAD_BITS), 8'd7);
    send_stream(40);
    write_reg(4'd9, 8'hFF);
    send_item('{lzwd_pkg::CMD_RESTART, 8'h5A});
    end_burst();
    write_reg(4'(lzwd_pkg::REG_WINDOW_BITS), 8'd7);
    write_reg(4'(lzwd_pkg::REG_LOOKAHEAD_BITS), 8'd5);
    for (int k = 0; k < 30; k++)
      send_item('{($urandom_range(0, 30) == 0) ? lzwd_pkg::CMD_RESTART : lzwd_pkg::CMD_DATA,
                  8'($urandom)});
    end_burst();
    send_stream(80);

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
src/lzwd_pkg.sv
src/lzwd_parser.sv
src/lzwd_cmd_queue.sv
src/lzwd_copy_engine.sv
src/lzss_window_decoder.sv
dv/lzss_window_decoder_tb.sv
